[src/rrts_pkg.sv]
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

   // Action codes
   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_SWITCH = 3'd1,
      ACT_SLEEP  = 3'd2,
      ACT_WAIT   = 3'd3,
      ACT_RESUME = 3'd4
   } action_type;

   // Error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BAD_ID  = 2'd1;
   localparam logic [1:0] ERR_FULL    = 2'd2;
   localparam logic [1:0] ERR_NO_TASK = 2'd3;

   // Task states
   localparam logic [1:0] ST_READY    = 2'd0;
   localparam logic [1:0] ST_RUNNING  = 2'd1;
   localparam logic [1:0] ST_SLEEPING = 2'd2;

   localparam logic [19:0] NS_PER_MS = 20'd1000000;

   // Request word layout: action, cpu, task_id, now_ns, sleep_ms, event_type, event_param
   localparam int REQ_BITS = 3 + 2 + 5 + 64 + 32 + 8 + 32;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   // Response word: next_task, is_idle, woke_any, delivered_param, switch_ticks, error
   localparam int RSP_BITS = 5 + 1 + 1 + 32 + 64 + 2;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   // Table entry held in the task memory
   typedef struct packed {
      logic [1:0]  state;
      logic [63:0] wake;
      logic [7:0]  wait_type;
      logic [31:0] param;
   } task_entry_type;

endpackage

[src/rrts_wake_mult.sv]
// Two-stage wake time unit: now + ms * 1e6, split into 16-bit partial products.
module rrts_wake_mult (
   input  logic        clock,
   input  logic        start,
   input  logic [63:0] now_ns,
   input  logic [31:0] sleep_ms,
   output logic [63:0] wake_at
);
   import rrts_pkg::*;

   logic [35:0] lo_prod_ff;
   logic [35:0] hi_prod_ff;
   logic [63:0] now_ff;

   // stage 1: partial products, widened before the multiply
   always_ff @(posedge clock) begin
      if (start) begin
         lo_prod_ff <= 36'(sleep_ms[15:0]) * 36'(NS_PER_MS);
         hi_prod_ff <= 36'(sleep_ms[31:16]) * 36'(NS_PER_MS);
         now_ff     <= now_ns;
      end
   end

   // stage 2: recombine, wraps modulo 2^64
   assign wake_at = now_ff + 64'(lo_prod_ff) + {12'd0, hi_prod_ff, 16'd0};
endmodule

[src/rrts_fifo_mem.sv]
// Ready-queue memory of task ids, one write and one registered read per cycle.
module rrts_fifo_mem #(
   parameter int AW = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);
   logic [AW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/rrts_task_mem.sv]
// Task table memory, one write and one registered read per cycle.
module rrts_task_mem #(
   parameter int AW = 5
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  rrts_pkg::task_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output rrts_pkg::task_entry_type rd_data
);
   import rrts_pkg::*;

   task_entry_type mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/round_robin_task_scheduler_unit.sv]
// Top level of the round-robin task scheduler: sequencer around queue and task memories.
//
//  channel | dir | ports                         | word
//  req     | in  | req_tvalid/tready/tdata       | one action
//  rsp     | out | rsp_tvalid/tready/tdata       | one result per action
//
// One word at a time, taken only in idle. Add steps through S_ADD, S_RUN_RD
// and S_RESP; a rejected add or an unused action skips S_ADD. Switch/sleep/wait
// rewrite the current entry and scan the queue until one qualifies; resume
// visits every queued task. Registered reads of the two memories pace each step.
// Synchronous reset clears head, count, cpu table and counters; memories are
// not cleared. A stalled response sits in the output register; the next word
// is still taken, and its result waits in the last state until the register frees.
module round_robin_task_scheduler_unit #(
   parameter int TASKS = 32,
   parameter int CPUS  = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // action[2:0], cpu[4:3], task_id[9:5], now_ns[73:10], sleep_ms[105:74],
   // event_type[113:106], event_param[145:114]
   input  logic [rrts_pkg::REQ_BYTES*8-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // next_task[4:0], is_idle[5], woke_any[6], delivered_param[38:7],
   // switch_ticks[102:39], error[104:103]
   output logic [rrts_pkg::RSP_BYTES*8-1:0]   rsp_tdata
);
   import rrts_pkg::*;

   localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int NW = AW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_REQ_RD, S_REQ_WR, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_EVAL,
      S_FIN_RD, S_FIN_WAIT, S_FIN_WR, S_RES_RD, S_RES_WAIT, S_RES_EVAL, S_RUN_RD,
      S_RESP
   } state_type;

   // request fields
   logic [2:0]  f_action;
   logic [1:0]  f_cpu;
   logic [4:0]  f_id;
   logic [63:0] f_now;
   logic [31:0] f_ms;
   logic [7:0]  f_ev;
   logic [31:0] f_par;
   assign f_action = req_tdata[2:0];
   assign f_cpu    = req_tdata[4:3];
   assign f_id     = req_tdata[9:5];
   assign f_now    = req_tdata[73:10];
   assign f_ms     = req_tdata[105:74];
   assign f_ev     = req_tdata[113:106];
   assign f_par    = req_tdata[145:114];

   state_type      state_ff;
   logic [2:0]     act_ff;
   logic [CW-1:0]  cpu_ff;
   logic [4:0]     id_ff;
   logic [63:0]    now_ff;
   logic [7:0]     ev_ff;
   logic [31:0]    par_ff;
   logic [1:0]     err_ff;
   logic           woke_ff;
   logic [AW-1:0]  head_ff;
   logic [NW-1:0]  count_ff;
   logic [NW-1:0]  left_ff;
   logic [AW-1:0]  next_ff;
   logic [AW-1:0]  cur_ff;
   logic           rsp_valid_ff;
   logic [RSP_BYTES*8-1:0] rsp_data_ff;
   logic [AW-1:0]  cpu_cur_ff [CPUS];
   logic [63:0]    cpu_sw_ff [CPUS];

   // memory ports
   logic           fq_we;
   logic [AW-1:0]  fq_wa, fq_wd, fq_ra, fq_rd;
   logic           tm_we;
   logic [AW-1:0]  tm_wa, tm_ra;
   task_entry_type tm_wd, tm_rd;
   logic [63:0]    wake_at;
   logic           wake_start;

   rrts_fifo_mem #(.AW(AW)) u_fifo (
      .clock(clock), .wr_en(fq_we), .wr_addr(fq_wa), .wr_data(fq_wd),
      .rd_addr(fq_ra), .rd_data(fq_rd));

   rrts_task_mem #(.AW(AW)) u_tasks (
      .clock(clock), .wr_en(tm_we), .wr_addr(tm_wa), .wr_data(tm_wd),
      .rd_addr(tm_ra), .rd_data(tm_rd));

   rrts_wake_mult u_wake (
      .clock(clock), .start(wake_start), .now_ns(f_now), .sleep_ms(f_ms),
      .wake_at(wake_at));

   assign wake_start = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // helpers
   logic [31:0]   cpu_wide;
   logic [CW-1:0] cpu_sel;
   logic [AW-1:0] tail_pos;
   logic [AW-1:0] pop_id;
   logic          qualifies;
   logic          id_ok;
   logic          q_full;
   logic          rsp_free;
   logic [AW-1:0] run_id;
   logic [31:0]   run_param;
   // cpu field modulo CPUS: one compare and subtract covers a 2-bit field
   assign cpu_wide = {30'd0, f_cpu};
   assign cpu_sel  = (CPUS == 1) ? '0 :
                     (cpu_wide >= 32'(CPUS)) ? CW'(cpu_wide - 32'(CPUS)) : CW'(cpu_wide);
   assign tail_pos = head_ff + count_ff[AW-1:0];
   assign pop_id   = (32'(fq_rd) < TASKS) ? fq_rd : '0;
   assign id_ok    = (f_id != 5'd0) && (32'(f_id) < TASKS);
   assign q_full   = (32'(count_ff) >= TASKS);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign run_id   = cpu_cur_ff[cpu_ff];
   assign run_param = (run_id == '0) ? 32'd0 : tm_rd.param;
   assign qualifies = (tm_rd.state == ST_READY) ||
                      ((tm_rd.state == ST_SLEEPING) && (tm_rd.wake != 64'd0) &&
                       (now_ff >= tm_rd.wake));

   // memory control from state
   always_comb begin
      fq_we = 1'b0; fq_wa = tail_pos; fq_wd = '0; fq_ra = head_ff;
      tm_we = 1'b0; tm_wa = '0; tm_wd = '0; tm_ra = cur_ff;
      case (state_ff)
         S_ADD: begin
            fq_we = 1'b1; fq_wd = AW'(id_ff);
            tm_we = 1'b1; tm_wa = AW'(id_ff);
            tm_wd = '{state: ST_READY, wake: 64'd0, wait_type: 8'd0, param: 32'd0};
         end
         S_REQ_WR: begin
            // requeue the current task if room; apply sleep or wait, or mark it ready
            if (cur_ff != '0 && !q_full) begin
               fq_we = 1'b1; fq_wd = cur_ff;
            end
            if (cur_ff != '0) begin
               tm_we = 1'b1; tm_wa = cur_ff; tm_wd = tm_rd;
               if (act_ff == ACT_SLEEP) begin
                  tm_wd.state     = ST_SLEEPING;
                  tm_wd.wake      = wake_at;
                  tm_wd.wait_type = 8'd0;
               end else if (act_ff == ACT_WAIT) begin
                  tm_wd.state     = ST_SLEEPING;
                  tm_wd.wake      = 64'd0;
                  tm_wd.wait_type = ev_ff;
                  tm_wd.param     = par_ff;
               end else if (tm_rd.state == ST_RUNNING) begin
                  tm_wd.state = ST_READY;
               end
            end
         end
         S_SCAN_RD: fq_ra = head_ff;
         S_SCAN_WAIT: tm_ra = pop_id;
         S_SCAN_EVAL: begin
            if (!qualifies) begin
               fq_we = 1'b1; fq_wd = fq_rd;
            end
         end
         S_FIN_RD: tm_ra = next_ff;
         S_FIN_WAIT: tm_ra = next_ff;
         S_FIN_WR: begin
            if (next_ff != '0) begin
               tm_we = 1'b1; tm_wa = next_ff; tm_wd = tm_rd; tm_wd.state = ST_RUNNING;
            end
         end
         S_RES_RD: fq_ra = head_ff + left_ff[AW-1:0];
         S_RES_WAIT: begin
            fq_ra = head_ff + left_ff[AW-1:0];
            tm_ra = pop_id;
         end
         S_RES_EVAL: begin
            tm_wa = pop_id; tm_wd = tm_rd; tm_wd.state = ST_READY; tm_wd.param = par_ff;
            tm_we = (tm_rd.state == ST_SLEEPING) && (tm_rd.wait_type == ev_ff);
         end
         S_RUN_RD: tm_ra = run_id;
         S_RESP: tm_ra = run_id;
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CPUS; i++) begin
            cpu_cur_ff[i] <= '0;
            cpu_sw_ff[i]  <= '0;
         end
      end else begin
         // output register: load a finished result, or drop the one taken
         if ((state_ff == S_RESP) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {7'd0, err_ff, cpu_sw_ff[cpu_ff], run_param, woke_ff,
                             (run_id == '0), 5'(run_id)};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  act_ff  <= f_action;
                  cpu_ff  <= cpu_sel;
                  id_ff   <= f_id;
                  now_ff  <= f_now;
                  ev_ff   <= f_ev;
                  par_ff  <= f_par;
                  woke_ff <= 1'b0;
                  cur_ff  <= cpu_cur_ff[cpu_sel];
                  left_ff <= '0;
                  case (f_action)
                     ACT_ADD: begin
                        if (!id_ok) begin
                           err_ff <= ERR_BAD_ID; state_ff <= S_RUN_RD;
                        end else if (q_full) begin
                           err_ff <= ERR_FULL; state_ff <= S_RUN_RD;
                        end else begin
                           err_ff <= ERR_NONE; state_ff <= S_ADD;
                        end
                     end
                     ACT_SWITCH: begin
                        err_ff <= ERR_NONE; state_ff <= S_REQ_RD;
                     end
                     ACT_SLEEP, ACT_WAIT: begin
                        err_ff <= (cpu_cur_ff[cpu_sel] == '0) ? ERR_NO_TASK : ERR_NONE;
                        state_ff <= S_REQ_RD;
                     end
                     ACT_RESUME: begin
                        err_ff <= ERR_NONE; state_ff <= S_RES_RD;
                     end
                     default: begin
                        err_ff <= ERR_NONE; state_ff <= S_RUN_RD;
                     end
                  endcase
               end
            end
            S_ADD: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_RUN_RD;
            end
            S_REQ_RD: state_ff <= S_REQ_WR;
            S_REQ_WR: begin
               if (cur_ff != '0) begin
                  if (!q_full) begin
                     count_ff <= count_ff + 1'b1;
                     left_ff  <= count_ff + 1'b1;
                  end else begin
                     left_ff <= count_ff;
                     if (err_ff == ERR_NONE) err_ff <= ERR_FULL;
                  end
               end else begin
                  left_ff <= count_ff;
               end
               next_ff  <= '0;
               state_ff <= S_SCAN_RD;
            end
            S_SCAN_RD: begin
               if (left_ff == '0) begin
                  state_ff <= S_FIN_RD;
               end else begin
                  state_ff <= S_SCAN_WAIT;
               end
            end
            S_SCAN_WAIT: state_ff <= S_SCAN_EVAL;
            S_SCAN_EVAL: begin
               head_ff <= head_ff + 1'b1;
               left_ff <= left_ff - 1'b1;
               if (qualifies) begin
                  count_ff <= count_ff - 1'b1;
                  next_ff  <= pop_id;
                  state_ff <= S_FIN_RD;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_FIN_RD: state_ff <= S_FIN_WAIT;
            S_FIN_WAIT: state_ff <= S_FIN_WR;
            S_FIN_WR: begin
               cpu_cur_ff[cpu_ff] <= next_ff;
               cpu_sw_ff[cpu_ff]  <= cpu_sw_ff[cpu_ff] + 64'd1;
               state_ff <= S_RUN_RD;
            end
            S_RES_RD: begin
               if (left_ff == count_ff) begin
                  state_ff <= S_RUN_RD;
               end else begin
                  state_ff <= S_RES_WAIT;
               end
            end
            S_RES_WAIT: state_ff <= S_RES_EVAL;
            S_RES_EVAL: begin
               if (tm_we) woke_ff <= 1'b1;
               left_ff  <= left_ff + 1'b1;
               state_ff <= S_RES_RD;
            end
            // read the running task's entry after every table update
            S_RUN_RD: state_ff <= S_RESP;
            S_RESP: begin
               if (rsp_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TASKS) else $error("queue count beyond depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response word changed");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> rsp_valid_ff) else $error("response not raised");
endmodule

[tb/sv/rrts_scoreboard.sv]
// Checker for the task scheduler: predicts every result word and compares it.
`timescale 1ns / 100ps

module rrts_scoreboard #(
   parameter int TASKS = 32,
   parameter int CPUS  = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [rrts_pkg::REQ_BYTES*8-1:0]   req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [rrts_pkg::RSP_BYTES*8-1:0]   rsp_tdata,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);
   import rrts_pkg::*;

   // highest field first, so next_task lands in the low bits
   typedef struct packed {
      logic [1:0]  error;
      logic [63:0] switch_ticks;
      logic [31:0] delivered_param;
      logic        woke_any;
      logic        is_idle;
      logic [4:0]  next_task;
   } sched_result_type;

   // shadow copy of the scheduler state
   logic [4:0]  run_queue [TASKS];
   int          rq_head;
   int          rq_count;
   logic [1:0]  tsk_state [TASKS];
   logic [63:0] tsk_wake  [TASKS];
   logic [7:0]  tsk_wtype [TASKS];
   logic [31:0] tsk_param [TASKS];
   logic [4:0]  cpu_task  [CPUS];
   logic [63:0] cpu_ticks [CPUS];

   sched_result_type expected_results [$];

   function automatic void rq_push(logic [4:0] id);
      run_queue[(rq_head + rq_count) % TASKS] = id;
      rq_count++;
   endfunction

   function automatic logic [4:0] rq_pop();
      logic [4:0] id;
      id = run_queue[rq_head];
      rq_head = (rq_head + 1) % TASKS;
      rq_count--;
      return id;
   endfunction

   // requeue current task, then pick the first runnable entry from the head
   function automatic logic [1:0] pick_next(int c, logic [63:0] now);
      logic [1:0] err;
      logic [4:0] cur;
      logic [4:0] nxt;
      logic [4:0] t;
      int         n;
      err = ERR_NONE;
      cur = cpu_task[c];
      nxt = '0;
      if (cur != 0) begin
         if (tsk_state[cur] == ST_RUNNING) tsk_state[cur] = ST_READY;
         if (rq_count < TASKS) rq_push(cur);
         else err = ERR_FULL;
      end
      cpu_task[c] = '0;
      n = rq_count;
      for (int k = 0; k < n; k++) begin
         t = rq_pop();
         if (tsk_state[t] == ST_READY ||
             (tsk_state[t] == ST_SLEEPING && tsk_wake[t] != 0 && now >= tsk_wake[t])) begin
            nxt = t;
            break;
         end
         rq_push(t);
      end
      if (nxt != 0) tsk_state[nxt] = ST_RUNNING;
      cpu_task[c] = nxt;
      cpu_ticks[c]++;
      return err;
   endfunction

   function automatic sched_result_type predict_result(logic [REQ_BYTES*8-1:0] w);
      logic [2:0]       act;
      int               c;
      logic [4:0]       id;
      logic [63:0]      now;
      logic [31:0]      ms;
      logic [7:0]       ev;
      logic [31:0]      par;
      logic [1:0]       err;
      logic [1:0]       err2;
      logic             woke;
      logic [4:0]       cur;
      logic [4:0]       t;
      sched_result_type r;
      act = w[2:0];
      c   = int'(w[4:3]) % CPUS;
      id  = w[9:5];
      now = w[73:10];
      ms  = w[105:74];
      ev  = w[113:106];
      par = w[145:114];
      err = ERR_NONE;
      woke = 1'b0;
      case (act)
         ACT_ADD: begin
            if (id == 0 || int'(id) >= TASKS) err = ERR_BAD_ID;
            else if (rq_count >= TASKS) err = ERR_FULL;
            else begin
               tsk_state[id] = ST_READY;
               tsk_wake[id]  = '0;
               tsk_wtype[id] = '0;
               tsk_param[id] = '0;
               rq_push(id);
            end
         end
         ACT_SWITCH: err = pick_next(c, now);
         ACT_SLEEP, ACT_WAIT: begin
            cur = cpu_task[c];
            if (cur == 0) err = ERR_NO_TASK;
            else if (act == ACT_SLEEP) begin
               tsk_wake[cur]  = now + 64'(ms) * 64'(NS_PER_MS);
               tsk_wtype[cur] = '0;
               tsk_state[cur] = ST_SLEEPING;
            end else begin
               tsk_wake[cur]  = '0;
               tsk_wtype[cur] = ev;
               tsk_param[cur] = par;
               tsk_state[cur] = ST_SLEEPING;
            end
            err2 = pick_next(c, now);
            if (err == ERR_NONE) err = err2;
         end
         ACT_RESUME: begin
            for (int i = 0; i < rq_count; i++) begin
               t = run_queue[(rq_head + i) % TASKS];
               if (tsk_state[t] == ST_SLEEPING && tsk_wtype[t] == ev) begin
                  tsk_state[t] = ST_READY;
                  tsk_param[t] = par;
                  woke = 1'b1;
               end
            end
         end
         default: ;
      endcase
      cur = cpu_task[c];
      r.next_task       = cur;
      r.is_idle         = (cur == 0);
      r.woke_any        = woke;
      r.delivered_param = (cur == 0) ? '0 : tsk_param[cur];
      r.switch_ticks    = cpu_ticks[c];
      r.error           = err;
      return r;
   endfunction

   assign pending = expected_results.size();

   // compare delivered words first, then predict for the accepted request
   always @(posedge clock) begin
      sched_result_type exp_r;
      sched_result_type got;
      if (reset) begin
         rq_head  = 0;
         rq_count = 0;
         for (int c = 0; c < CPUS; c++) begin
            cpu_task[c]  = '0;
            cpu_ticks[c] = '0;
         end
         expected_results.delete();
         fail_count <= 0;
         checked    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[104:0];
            checked <= checked + 1;
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected: %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (got.next_task !== exp_r.next_task)
                  $error("next_task: expected %0d, got %0d", exp_r.next_task, got.next_task);
               if (got.is_idle !== exp_r.is_idle)
                  $error("is_idle: expected %0d, got %0d", exp_r.is_idle, got.is_idle);
               if (got.woke_any !== exp_r.woke_any)
                  $error("woke_any: expected %0d, got %0d", exp_r.woke_any, got.woke_any);
               if (got.delivered_param !== exp_r.delivered_param)
                  $error("delivered_param: expected %h, got %h",
                         exp_r.delivered_param, got.delivered_param);
               if (got.switch_ticks !== exp_r.switch_ticks)
                  $error("switch_ticks: expected %0d, got %0d",
                         exp_r.switch_ticks, got.switch_ticks);
               if (got.error !== exp_r.error)
                  $error("error: expected %0d, got %0d", exp_r.error, got.error);
               if (got !== exp_r) fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_result(req_tdata));
      end
   end

endmodule

[tb/sv/round_robin_task_scheduler_unit_test.sv]
// Testbench top: drives request words and rsp backpressure, gives the verdict.
`timescale 1ns / 100ps

module round_robin_task_scheduler_unit_test;
   import rrts_pkg::*;

   localparam int TASKS       = 32;
   localparam int CPUS        = 4;
   localparam int RANDOM_WORDS = 1950;
   localparam int STALL_LIMIT = 5000;
   localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
   localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
   localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // action, cpu, task_id, now_ns, sleep_ms, event_type, event_param (low bit up)
   logic [REQ_BYTES*8-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // next_task, is_idle, woke_any, delivered_param, switch_ticks, error
   logic [RSP_BYTES*8-1:0] rsp_tdata;

   int          fail_count;
   int          pending;
   int          checked;
   int          words_sent = 0;
   int          quiet_cycles = 0;
   logic [63:0] sys_ns = 64'd1;

   always #1 clock = ~clock;

   round_robin_task_scheduler_unit #(.TASKS(TASKS), .CPUS(CPUS)) u_dut (.*);

   rrts_scoreboard #(.TASKS(TASKS), .CPUS(CPUS)) u_scoreboard (.*);

   // half no gap, most of the rest short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response backpressure with calm stretches
   int rsp_hold = 0;
   int rsp_calm = 0;
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 49) == 0) rsp_calm = $urandom_range(50, 300);
         else rsp_hold = pick_gap();
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(logic [2:0] act, logic [1:0] cpu, logic [4:0] id,
                            logic [63:0] now, logic [31:0] ms, logic [7:0] ev,
                            logic [31:0] par, int gap);
      req_tdata  <= {6'd0, par, ev, ms, now, id, cpu, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random word, weighted toward well-formed scheduling traffic
   task automatic send_random(int gap);
      int          r;
      logic [2:0]  act;
      logic [63:0] now;
      logic [31:0] ms;
      logic [7:0]  ev;
      r = $urandom_range(0, 99);
      if (r < 14)      act = ACT_ADD;
      else if (r < 48) act = ACT_SWITCH;
      else if (r < 64) act = ACT_SLEEP;
      else if (r < 78) act = ACT_WAIT;
      else if (r < 96) act = ACT_RESUME;
      else act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      sys_ns += 64'($urandom_range(0, 3000000));
      r = $urandom_range(0, 99);
      if (r < 92) now = sys_ns;
      else if (r < 97) now = {$urandom, $urandom};
      else now = '1;
      ms = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 3));
      ev = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      send_word(act, 2'($urandom), 5'($urandom), now, ms, ev, $urandom, gap);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a bad id, idle CPUs, extremes, unused actions
      send_word(ACT_ADD,    2'd0, 5'd0,  64'd0, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_SLEEP,  2'd3, 5'd0,  64'd5, 32'd1, 8'd0, 32'd0, 0);
      send_word(ACT_WAIT,   2'd2, 5'd0,  64'd5, 32'd0, 8'd9, 32'd7, 1);
      send_word(ACT_SWITCH, 2'd1, 5'd0,  64'd5, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_ADD,    2'd0, 5'd31, 64'd5, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_ADD,    2'd0, 5'd1,  64'd5, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_ADD,    2'd1, 5'd1,  64'd5, 32'd0, 8'd0, 32'd0, 2);
      send_word(ACT_SWITCH, 2'd0, 5'd0,  64'd6, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_SWITCH, 2'd1, 5'd0,  64'd6, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_SLEEP,  2'd0, 5'd0,  '1,    '1,    8'd0, 32'd0, 0);
      send_word(ACT_WAIT,   2'd1, 5'd0,  64'd7, 32'd0, 8'd255, '1, 0);
      send_word(ACT_RESUME, 2'd2, 5'd0,  64'd8, 32'd0, 8'd0,  32'd3, 0);
      send_word(ACT_RESUME, 2'd1, 5'd0,  64'd8, 32'd0, 8'd255, 32'hA5A5_5A5A, 0);
      send_word(ACT_SWITCH, 2'd3, 5'd0,  '1,    32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_UNUSED_LO, 2'd3, 5'd31, '1,  '1, '1, '1, 0);
      send_word(ACT_UNUSED_MID, 2'd2, 5'd0, 64'd0, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_UNUSED_HI, 2'd1, 5'd0, 64'd0, 32'd0, 8'd0, 32'd0, 3);
      // fill the queue until add hits full, then switch on CPU 2
      for (int i = 1; i < TASKS + 4; i++)
         send_word(ACT_ADD, 2'd0, 5'(i), 64'd9, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_SWITCH, 2'd2, 5'd0, 64'd10, 32'd0, 8'd0, 32'd0, 0);
      send_word(ACT_SWITCH, 2'd2, 5'd0, 64'd10, 32'd0, 8'd0, 32'd0, 0);

      // random traffic with occasional back-to-back stretches
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 199) == 0)
            for (int k = 0; k < 40; k++) send_random(0);
         else send_random(pick_gap());
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d request words, checked %0d result words", words_sent, checked);
      $display("covered adds, switches, sleeps, waits, resumes and unused actions");
      if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
